// ----- design/slasm_pkg.sv -----
// Shared constants and types of the serial line assembler.
package slasm_pkg;

   localparam int LINE_BUFFER_BYTES = 64;
   localparam int LINE_CAPACITY     = LINE_BUFFER_BYTES - 1;
   localparam int FILL_W            = $clog2(LINE_CAPACITY + 1);
   localparam int IDX_W             = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

   localparam int          PADDR_W             = 3;
   localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd1000;
   localparam logic [7:0]  CHAR_LF             = 8'h0A;
   localparam logic [7:0]  CHAR_CR             = 8'h0D;

   localparam logic KIND_LINE   = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   localparam logic REG_STALE_TIMEOUT = 1'b0;

   typedef logic [7:0]  byte_type;
   typedef logic [31:0] ms_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SEND,
      ST_NOTICE
   } state_type;

   typedef struct packed {
      logic take;
      logic fetch;
      logic advance;
      logic notice;
   } ctl_cmd_type;

   typedef struct packed {
      logic start_drain;
      logic start_notice;
      logic last_beat;
   } ctl_status_type;

endpackage

// ----- design/slasm_if.sv -----
// Valid/ready channel interfaces for received bytes and result beats.
interface slasm_req_if;
   import slasm_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;
   ms_type   now_ms;

   modport source (output valid, output rx_byte, output now_ms, input ready);
   modport sink   (input valid, input rx_byte, input now_ms, output ready);
endinterface

interface slasm_rsp_if;
   import slasm_pkg::*;

   logic     valid;
   logic     ready;
   logic     kind;
   byte_type line_byte;
   logic     last;

   modport source (output valid, output kind, output line_byte, output last, input ready);
   modport sink   (input valid, input kind, input line_byte, input last, output ready);
endinterface

// ----- design/serial_line_assembler_core.sv -----
// Serial line assembler: builds received bytes into lines with a stale timeout.
//
// Takes one received byte per cycle while no result is pending. A CR or LF
// closes the line; a non-empty line is then read back from a 63-byte line
// store and sent as rsp beats, the final one marked last. Input is held off
// while a line drains: each line byte goes through a registered read of the
// line store, then the output beat, which waits while rsp_chan.ready stays
// low. A byte arriving on a full store produces one overflow notice beat
// (kind 1, last 1), which blocks input until it is taken; later bytes are
// dropped until a terminator. The stale timeout register sits at byte
// address 0 (reset 1000 ms); it should be written only while the block is
// idle.
module serial_line_assembler_core (
   input  logic                              clock,
   input  logic                              reset,
   slasm_req_if.sink                         req_chan,
   slasm_rsp_if.source                       rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [slasm_pkg::PADDR_W-1:0]     paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import slasm_pkg::*;

   ctl_cmd_type    cmd;
   ctl_status_type status;
   logic           cfg_we;
   ms_type         timeout_ms;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_STALE_TIMEOUT);
   assign prdata = (paddr[PADDR_W-1] == REG_STALE_TIMEOUT) ? timeout_ms : '0;

   slasm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_kind  (rsp_chan.kind),
      .rsp_last  (rsp_chan.last),
      .status    (status),
      .cmd       (cmd)
   );

   slasm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .rx_byte    (req_chan.rx_byte),
      .now_ms     (req_chan.now_ms),
      .cfg_we     (cfg_we),
      .cfg_data   (pwdata),
      .timeout_ms (timeout_ms),
      .cmd        (cmd),
      .status     (status),
      .line_byte  (rsp_chan.line_byte)
   );

endmodule

// ----- design/slasm_ctrl.sv -----
// Sequencer: accepts bytes, walks the line store while a line drains, sends overflow notices.
module slasm_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_kind,
   output logic                      rsp_last,
   input  slasm_pkg::ctl_status_type status,
   output slasm_pkg::ctl_cmd_type    cmd
);
   import slasm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_kind    = KIND_LINE;
      rsp_last    = 1'b0;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.start_drain) begin
                  state_in = ST_FETCH;
               end else if (status.start_notice) begin
                  state_in = ST_NOTICE;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            rsp_last  = status.last_beat;
            if (rsp_ready) begin
               if (status.last_beat) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_NOTICE: begin
            rsp_valid  = 1'b1;
            rsp_kind   = KIND_NOTICE;
            rsp_last   = 1'b1;
            cmd.notice = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/slasm_datapath.sv -----
// Line store, fill and timeout state, drain pointer and timeout register.
module slasm_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  slasm_pkg::byte_type       rx_byte,
   input  slasm_pkg::ms_type         now_ms,
   input  logic                      cfg_we,
   input  slasm_pkg::ms_type         cfg_data,
   output slasm_pkg::ms_type         timeout_ms,
   input  slasm_pkg::ctl_cmd_type    cmd,
   output slasm_pkg::ctl_status_type status,
   output slasm_pkg::byte_type       line_byte
);
   import slasm_pkg::*;

   byte_type line_store [LINE_CAPACITY];

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              discarding_ff, discarding_in;
   ms_type            last_time_ff, last_time_in;
   logic              time_valid_ff, time_valid_in;
   ms_type            timeout_ff;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic [FILL_W-1:0] drain_len_ff, drain_len_in;
   byte_type          rd_data_ff;

   logic              term;
   logic              stale;
   ms_type            gap;
   logic [FILL_W-1:0] eff_fill;
   logic              wr_en;

   assign term     = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
   assign gap      = now_ms - last_time_ff;
   assign stale    = (fill_ff != '0) && time_valid_ff && (gap > timeout_ff);
   assign eff_fill = stale ? '0 : fill_ff;

   always_comb begin
      fill_in             = fill_ff;
      discarding_in       = discarding_ff;
      last_time_in        = last_time_ff;
      time_valid_in       = time_valid_ff;
      rd_idx_in           = rd_idx_ff;
      drain_len_in        = drain_len_ff;
      wr_en               = 1'b0;
      status.start_drain  = 1'b0;
      status.start_notice = 1'b0;
      status.last_beat    = (FILL_W'(rd_idx_ff) + FILL_W'(1)) == drain_len_ff;
      if (discarding_ff) begin
         // drop everything until a terminator
         if (term) begin
            fill_in       = '0;
            discarding_in = 1'b0;
            time_valid_in = 1'b0;
         end
      end else if (term) begin
         status.start_drain = (eff_fill != '0);
         drain_len_in       = eff_fill;
         rd_idx_in          = '0;
         fill_in            = '0;
         time_valid_in      = 1'b0;
      end else if (eff_fill < FILL_W'(LINE_CAPACITY)) begin
         wr_en         = 1'b1;
         fill_in       = eff_fill + FILL_W'(1);
         last_time_in  = now_ms;
         time_valid_in = 1'b1;
      end else begin
         status.start_notice = 1'b1;
         discarding_in       = 1'b1;
         last_time_in        = now_ms;
         time_valid_in       = 1'b1;
      end
      if (cmd.advance) begin
         rd_idx_in = rd_idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         discarding_ff <= 1'b0;
         last_time_ff  <= '0;
         time_valid_ff <= 1'b0;
         timeout_ff    <= STALE_TIMEOUT_RESET;
      end else begin
         if (cmd.take) begin
            fill_ff       <= fill_in;
            discarding_ff <= discarding_in;
            last_time_ff  <= last_time_in;
            time_valid_ff <= time_valid_in;
         end
         if (cfg_we) begin
            timeout_ff <= cfg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take || cmd.advance) begin
         rd_idx_ff <= rd_idx_in;
      end
      if (cmd.take) begin
         drain_len_ff <= drain_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && wr_en) begin
         line_store[eff_fill[IDX_W-1:0]] <= rx_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= line_store[rd_idx_ff];
      end
   end

   assign line_byte  = cmd.notice ? '0 : rd_data_ff;
   assign timeout_ms = timeout_ff;

endmodule

// ----- design/slasm_checker.sv -----
// Port-level checks for the serial line assembler, bound to the top level.
module slasm_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_kind,
   input logic [7:0]                 rsp_line_byte,
   input logic                       rsp_last
);
   import slasm_pkg::*;

   // hold a pending beat until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped before handshake");

   // never take a byte while a result is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && rsp_valid))
      else $error("req accepted while rsp pending");

   a_notice_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_NOTICE) |-> rsp_last && (rsp_line_byte == 8'd0))
      else $error("malformed overflow notice");

   // reopen input right after the closing beat
   a_resume: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("input not resumed after last beat");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind serial_line_assembler_core slasm_checker u_slasm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_line_byte (rsp_chan.line_byte),
   .rsp_last      (rsp_chan.last)
);

// ----- verif/slasm_tb_pkg.sv -----
// Line predictor and result scoreboard for the serial line assembler testbench.
`timescale 1ns / 100ps
package slasm_tb_pkg;
   import slasm_pkg::*;

   typedef struct {
      logic     kind;
      logic [7:0] line_byte;
      logic     last;
   } line_beat_type;

   class line_scoreboard;
      byte_type            line_bytes[LINE_CAPACITY];
      logic [FILL_W-1:0]   fill_count;
      bit                  dropping;
      ms_type              last_stamp;
      bit                  stamp_ok;
      ms_type              timeout_ms;
      line_beat_type       expected_beats[$];
      int                  errors;

      function new();
         fill_count = '0;
         dropping   = 1'b0;
         last_stamp = '0;
         stamp_ok   = 1'b0;
         timeout_ms = STALE_TIMEOUT_RESET;
         errors     = 0;
      endfunction

      function void set_timeout(ms_type value);
         timeout_ms = value;
      endfunction

      // Returns 1 when the byte did something, 0 when the assembler ignored it.
      function bit note_byte(byte_type rx, ms_type stamp);
         bit            is_term;
         line_beat_type beat;
         is_term = (rx == CHAR_LF) || (rx == CHAR_CR);
         if (dropping) begin
            if (is_term) begin
               fill_count = '0;
               dropping   = 1'b0;
               stamp_ok   = 1'b0;
            end
            return is_term;
         end
         // drop a partial line whose previous byte is too old
         if (fill_count != 0 && stamp_ok && ms_type'(stamp - last_stamp) > timeout_ms) begin
            fill_count = '0;
            stamp_ok   = 1'b0;
         end
         if (is_term) begin
            for (int i = 0; i < fill_count; i++) begin
               beat.kind      = KIND_LINE;
               beat.line_byte = line_bytes[i];
               beat.last      = (i + 1 == fill_count);
               expected_beats.push_back(beat);
            end
            fill_count = '0;
            stamp_ok   = 1'b0;
            return 1'b1;
         end
         last_stamp = stamp;
         stamp_ok   = 1'b1;
         if (fill_count < LINE_CAPACITY) begin
            line_bytes[fill_count] = rx;
            fill_count++;
            return 1'b1;
         end
         dropping       = 1'b1;
         beat.kind      = KIND_NOTICE;
         beat.line_byte = 8'h00;
         beat.last      = 1'b1;
         expected_beats.push_back(beat);
         return 1'b1;
      endfunction

      function void check_beat(logic kind, byte_type line_byte, logic last);
         line_beat_type want;
         if (expected_beats.size() == 0) begin
            $error("unexpected beat: kind %0d line_byte %02h last %0d", kind, line_byte, last);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
         end
         if (line_byte !== want.line_byte) begin
            $error("line_byte: expected %02h, got %02h", want.line_byte, line_byte);
            errors++;
         end
         if (last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, last);
            errors++;
         end
      endfunction

      function int beats_owed();
         return expected_beats.size();
      endfunction
   endclass

endpackage

// ----- verif/tb_serial_line_assembler_core.sv -----
// Self-checking testbench of serial_line_assembler_core with random traffic.
`timescale 1ns / 100ps
module tb_serial_line_assembler_core;
   import slasm_pkg::*;
   import slasm_tb_pkg::*;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 100;

   logic                clock;
   logic                reset;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [PADDR_W-1:0]  paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   slasm_req_if req_chan();
   slasm_rsp_if rsp_chan();

   serial_line_assembler_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   line_scoreboard board = new();
   ms_type         cur_ms;
   int             items_taken;
   int             quiet_cycles;
   bit             send_calm;
   bit             take_calm;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // abort when nothing moves on either channel for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // result side: random stalls, with calm stretches
   initial begin
      int stall;
      int beats;
      beats = 0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (beats % 24 == 0) begin
            take_calm = ($urandom_range(0, 3) == 0);
         end
         stall = take_calm ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         board.check_beat(rsp_chan.kind, rsp_chan.line_byte, rsp_chan.last);
         beats++;
      end
   end

   task automatic send_byte(input byte_type rx, input ms_type stamp);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= rx;
      req_chan.now_ms  <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      if (board.note_byte(rx, stamp)) begin
         items_taken++;
      end
   endtask

   // hold input low until every owed beat is out and the block has settled
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (board.beats_owed() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input ms_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'(4 * int'(REG_STALE_TIMEOUT));
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      board.set_timeout(value);
   endtask

   function automatic ms_type draw_gap(bit keep_line);
      ms_type near;
      near = (board.timeout_ms > 1000) ? ms_type'(1000) : board.timeout_ms;
      if (keep_line && $urandom_range(0, 19) != 0) begin
         return $urandom_range(0, near);
      end
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return board.timeout_ms;
         end
         2: begin
            return board.timeout_ms + 1;
         end
         3: begin
            return $urandom;
         end
         default: begin
            return $urandom_range(0, near);
         end
      endcase
   endfunction

   function automatic byte_type draw_text_byte();
      byte_type rx;
      do rx = byte_type'($urandom_range(0, 255)); while (rx == CHAR_LF || rx == CHAR_CR);
      return rx;
   endfunction

   // well-formed lines with random content; the first one is long enough to overflow
   task automatic run_random_phase(input int quota);
      int       target;
      int       len;
      bit       long_line;
      bit       first;
      byte_type rx;
      target = items_taken + quota;
      first  = 1'b1;
      cur_ms = $urandom;
      while (items_taken < target) begin
         if (first || $urandom_range(0, 6) == 0) begin
            len = $urandom_range(60, 70);
         end else begin
            len = $urandom_range(0, 12);
         end
         if (first) begin
            len = $urandom_range(64, 70);
         end
         long_line = (len >= 60);
         first     = 1'b0;
         send_calm = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < len; i++) begin
            rx     = ($urandom_range(0, 19) == 0) ? byte_type'($urandom_range(0, 255))
                                                  : draw_text_byte();
            cur_ms = cur_ms + draw_gap(long_line);
            send_byte(rx, cur_ms);
         end
         cur_ms = cur_ms + draw_gap(long_line);
         send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF, cur_ms);
      end
   endtask

   initial begin
      ms_type setting;
      items_taken      = 0;
      quiet_cycles     = 0;
      send_calm        = 1'b0;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      req_chan.now_ms  <= '0;
      psel             <= 1'b0;
      penable          <= 1'b0;
      pwrite           <= 1'b0;
      paddr            <= '0;
      pwdata           <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines at the reset timeout
      send_byte(CHAR_LF, 32'd0);
      send_byte(8'h00, 32'd0);
      send_byte(8'hFF, 32'd1000);
      send_byte(CHAR_CR, 32'd1000);
      send_byte(8'h41, 32'd5000);
      send_byte(8'h42, 32'd6001);
      send_byte(CHAR_LF, 32'd6001);
      send_byte(8'h7E, 32'hFFFF_FFF0);
      send_byte(8'h01, 32'h0000_0100);
      send_byte(CHAR_CR, 32'h0000_0100);
      send_byte(8'h55, 32'd100);
      send_byte(CHAR_LF, 32'd2000);
      send_byte(CHAR_CR, 32'd2000);
      send_byte(CHAR_LF, 32'd2000);
      send_byte(8'hAA, 32'hFFFF_FFFF);
      send_byte(8'h0B, 32'hFFFF_FFFF);
      send_byte(8'h0C, 32'd0);
      send_byte(8'h09, 32'd0);
      send_byte(CHAR_LF, 32'd0);

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               setting = '0;
            end
            1: begin
               setting = '1;
            end
            2: begin
               setting = $urandom_range(1, 2000);
            end
            3: begin
               setting = $urandom;
            end
            default: begin
               setting = STALE_TIMEOUT_RESET;
            end
         endcase
         wait_idle();
         write_timeout(setting);
         run_random_phase(PHASE_ITEMS);
      end

      wait_idle();
      if (board.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/slasm_pkg.sv
design/slasm_if.sv
design/slasm_ctrl.sv
design/slasm_datapath.sv
design/serial_line_assembler_core.sv
design/slasm_checker.sv
verif/slasm_tb_pkg.sv
verif/tb_serial_line_assembler_core.sv
